/* hw/rtl/mbrot_pkg.sv */
// Shared types and constants of the escape-time pixel evaluator.
// No dependencies; used by every module of the block.
`default_nettype none
package mbrot_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 12;
  localparam int unsigned DenW  = 13;
  localparam int unsigned NumW  = 46;  // signed (corner difference) * pixel index
  localparam int unsigned MagW  = 45;  // magnitude of that product
  localparam int unsigned GrayW = 8;

  typedef enum logic [2:0] {
    CfgLeftReal   = 3'd0,
    CfgTopImag    = 3'd1,
    CfgRightReal  = 3'd2,
    CfgBottomImag = 3'd3,
    CfgImgWidth   = 3'd4,
    CfgImgHeight  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
  } point_t;

  typedef enum logic [1:0] {
    FeIdle,
    FeMul,
    FeDiv,
    FePush
  } front_state_e;

  typedef enum logic [2:0] {
    BeIdle,
    BeRr,
    BeIi,
    BeRi,
    BeUpd
  } back_state_e;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = hi[DataW-1:0];
    end else if (v < lo) begin
      sat32 = lo[DataW-1:0];
    end else begin
      sat32 = v[DataW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/mandelbrot_escape_time_pixel.sv */
// Top level of the escape-time pixel evaluator: registers, front end, queue, engine.
// Depends on mbrot_pkg, mbrot_front, mbrot_queue and mbrot_back.
`default_nettype none
// A pixel request (column, row) is taken when start is high and busy is low.
// The front end maps the pixel onto the complex plane with two restoring
// dividers that produce one quotient bit per cycle; a request keeps busy
// high until its point is pushed. Mapped points wait in a two-entry queue,
// so the front end takes the next request while the iteration engine still
// works. The engine runs z = z*z + c through one shared 32x32 multiplier,
// stepping through the states BeRr, BeIi, BeRi and BeUpd for each iteration.
// Each result is presented for exactly one cycle with done_o high; the
// receiver cannot stall it. Configuration must be written only while the
// block is idle.
module mandelbrot_escape_time_pixel #(
  parameter int unsigned MAX_ITER  = 255,
  parameter int unsigned FRAC_BITS = 28
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [11:0] column_i,
  input  wire  [11:0] row_i,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [31:0] cfg_data_i,
  output logic        done_o,
  output logic [7:0]  gray_level_o,
  output logic        in_set_o
);

  // Corner points and image size, reset to a 4x4 window centered on zero.
  logic signed [31:0] left_real_q, top_imag_q, right_real_q, bottom_imag_q;
  logic [12:0]        image_width_q, image_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_real_q    <= -32'sd536870912;
      top_imag_q     <= 32'sd536870912;
      right_real_q   <= 32'sd536870912;
      bottom_imag_q  <= -32'sd536870912;
      image_width_q  <= 13'd1024;
      image_height_q <= 13'd1024;
    end else if (cfg_we_i) begin
      // Writes to an unknown index are ignored.
      unique case (mbrot_pkg::cfg_idx_e'(cfg_idx_i))
        mbrot_pkg::CfgLeftReal:   left_real_q    <= cfg_data_i;
        mbrot_pkg::CfgTopImag:    top_imag_q     <= cfg_data_i;
        mbrot_pkg::CfgRightReal:  right_real_q   <= cfg_data_i;
        mbrot_pkg::CfgBottomImag: bottom_imag_q  <= cfg_data_i;
        mbrot_pkg::CfgImgWidth:   image_width_q  <= cfg_data_i[12:0];
        mbrot_pkg::CfgImgHeight:  image_height_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  logic q_full, q_push, q_empty, q_pop;
  mbrot_pkg::point_t q_in, q_out;

  // Front end: accepts the request and maps it to the point c.
  mbrot_front u_front (
    .clk_i, .rst_ni, .start, .busy, .column_i, .row_i,
    .left_real_i(left_real_q), .top_imag_i(top_imag_q),
    .right_real_i(right_real_q), .bottom_imag_i(bottom_imag_q),
    .image_width_i(image_width_q), .image_height_i(image_height_q),
    .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_in)
  );

  mbrot_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(q_out)
  );

  // Back end: iterates until escape or the iteration limit.
  mbrot_back #(.MAX_ITER(MAX_ITER), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_data_i(q_out), .q_pop_o(q_pop),
    .done_o, .gray_level_o, .in_set_o
  );

  // A point in the set always reads as gray level zero.
  property p_in_set_zero;
    @(posedge clk_i) disable iff (!rst_ni) (done_o && in_set_o) |-> gray_level_o == 8'd0;
  endproperty
  assert property (p_in_set_zero) else $error("in-set point with nonzero gray level");

  // An escaped point never reads as zero.
  property p_escaped_nonzero;
    @(posedge clk_i) disable iff (!rst_ni) (done_o && !in_set_o) |-> gray_level_o != 8'd0;
  endproperty
  assert property (p_escaped_nonzero) else $error("escaped point with gray level zero");

  // The engine returns to idle and runs its multiply states for every point, so strobes never touch.
  property p_strobe_single;
    @(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o;
  endproperty
  assert property (p_strobe_single) else $error("back-to-back result strobes");

  // The queue is never written while full.
  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni) q_full |-> !q_push;
  endproperty
  assert property (p_no_overflow) else $error("queue overflow");

endmodule
`default_nettype wire

/* hw/rtl/mbrot_div.sv */
// Restoring divider, one quotient bit a cycle, plus the saturating corner add.
// Depends on mbrot_pkg.
`default_nettype none
module mbrot_div (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start_i,
  input  wire signed [mbrot_pkg::NumW-1:0]      num_i,
  input  wire        [mbrot_pkg::DenW-1:0]      den_i,
  input  wire signed [mbrot_pkg::DataW-1:0]     base_i,
  output logic                                  done_o,
  output logic signed [mbrot_pkg::DataW-1:0]    value_o
);

  localparam int unsigned CntW  = $clog2(mbrot_pkg::MagW + 1);
  localparam int unsigned NumWq = mbrot_pkg::MagW + 1;

  logic [mbrot_pkg::MagW-1:0] quo_q, quo_d;
  logic [mbrot_pkg::DenW-1:0] rem_q, rem_d;
  logic [mbrot_pkg::DenW-1:0] den_q;
  logic                       neg_q;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       run_q, run_d, fin_q, fin_d;
  logic [mbrot_pkg::DenW:0]   trial;
  logic signed [NumWq-1:0]    qs;
  logic signed [63:0]         sum;

  always_comb begin
    trial = {rem_q, quo_q[mbrot_pkg::MagW-1]};
    quo_d = {quo_q[mbrot_pkg::MagW-2:0], 1'b0};
    rem_d = trial[mbrot_pkg::DenW-1:0];
    if (trial >= {1'b0, den_q}) begin
      rem_d    = mbrot_pkg::DenW'(trial - {1'b0, den_q});
      quo_d[0] = 1'b1;
    end
    cnt_d = cnt_q + CntW'(1);
    run_d = run_q && (cnt_q != CntW'(mbrot_pkg::MagW - 1));
    fin_d = run_q && (cnt_q == CntW'(mbrot_pkg::MagW - 1));
  end

  always_comb begin
    qs  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    sum = 64'(base_i) + 64'(qs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_o <= 1'b0;
    end else begin
      run_q  <= start_i | run_d;
      fin_q  <= fin_d;
      done_o <= fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[mbrot_pkg::NumW-1];
      quo_q <= num_i[mbrot_pkg::NumW-1] ? mbrot_pkg::MagW'(-num_i)
                                        : mbrot_pkg::MagW'(num_i);
      rem_q <= '0;
      den_q <= (den_i == '0) ? mbrot_pkg::DenW'(1) : den_i;
      cnt_q <= '0;
    end else if (run_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      cnt_q <= cnt_d;
    end
    if (fin_q) begin
      value_o <= mbrot_pkg::sat32(sum);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/mbrot_front.sv */
// Front end: takes a pixel request, scales it and maps it onto the plane.
// Depends on mbrot_pkg and mbrot_div.
`default_nettype none
module mbrot_front (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start,
  output logic                               busy,
  input  wire        [mbrot_pkg::IdxW-1:0]   column_i,
  input  wire        [mbrot_pkg::IdxW-1:0]   row_i,
  input  wire signed [mbrot_pkg::DataW-1:0]  left_real_i,
  input  wire signed [mbrot_pkg::DataW-1:0]  top_imag_i,
  input  wire signed [mbrot_pkg::DataW-1:0]  right_real_i,
  input  wire signed [mbrot_pkg::DataW-1:0]  bottom_imag_i,
  input  wire        [mbrot_pkg::DenW-1:0]   image_width_i,
  input  wire        [mbrot_pkg::DenW-1:0]   image_height_i,
  input  wire                                q_full_i,
  output logic                               q_push_o,
  output mbrot_pkg::point_t                  q_data_o
);

  mbrot_pkg::front_state_e state_q, state_d;
  logic signed [mbrot_pkg::NumW-1:0] num_re_q, num_im_q;
  logic signed [mbrot_pkg::NumW-1:0] prod_re, prod_im;
  logic signed [mbrot_pkg::DataW:0]  diff_re, diff_im;
  logic div_start, re_done, im_done;
  logic signed [mbrot_pkg::DataW-1:0] re_val, im_val;
  logic accept;

  assign accept  = start && !busy;
  assign diff_re = $signed({right_real_i[31], right_real_i})
                 - $signed({left_real_i[31], left_real_i});
  assign diff_im = $signed({bottom_imag_i[31], bottom_imag_i})
                 - $signed({top_imag_i[31], top_imag_i});
  // Full-width products: the corner difference times the pixel index.
  assign prod_re = diff_re * $signed({1'b0, column_i});
  assign prod_im = diff_im * $signed({1'b0, row_i});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbrot_pkg::FeIdle: if (start) state_d = mbrot_pkg::FeMul;
      mbrot_pkg::FeMul:  state_d = mbrot_pkg::FeDiv;
      mbrot_pkg::FeDiv:  if (re_done) state_d = mbrot_pkg::FePush;
      mbrot_pkg::FePush: if (!q_full_i) state_d = mbrot_pkg::FeIdle;
      default:           state_d = mbrot_pkg::FeIdle;
    endcase
  end

  always_comb begin
    busy      = (state_q != mbrot_pkg::FeIdle);
    div_start = (state_q == mbrot_pkg::FeMul);
    q_push_o  = (state_q == mbrot_pkg::FePush) && !q_full_i;
    q_data_o  = '{re: re_val, im: im_val};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbrot_pkg::FeIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      num_re_q <= prod_re;
      num_im_q <= prod_im;
    end
  end

  mbrot_div u_div_re (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_re_q), .den_i(image_width_i),
    .base_i(left_real_i), .done_o(re_done), .value_o(re_val)
  );

  mbrot_div u_div_im (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_im_q), .den_i(image_height_i),
    .base_i(top_imag_i), .done_o(im_done), .value_o(im_val)
  );

  property p_lanes_lockstep;
    @(posedge clk_i) disable iff (!rst_ni) re_done == im_done;
  endproperty
  assert property (p_lanes_lockstep) else $error("divider lanes out of step");

  property p_push_after_div;
    @(posedge clk_i) disable iff (!rst_ni) re_done |-> state_q == mbrot_pkg::FeDiv;
  endproperty
  assert property (p_push_after_div) else $error("divider finished outside DIV");

  property p_no_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == mbrot_pkg::FeDiv) |=> state_q != mbrot_pkg::FeMul;
  endproperty
  assert property (p_no_accept_busy) else $error("front restarted mid division");

endmodule
`default_nettype wire

/* hw/rtl/mbrot_queue.sv */
// Two-entry queue of mapped points between front end and iteration engine.
// Depends on mbrot_pkg.
`default_nettype none
module mbrot_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  mbrot_pkg::point_t  data_i,
  output logic               full_o,
  input  wire                pop_i,
  output logic               empty_o,
  output mbrot_pkg::point_t  data_o
);

  mbrot_pkg::point_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/mbrot_back.sv */
// Iteration engine: z = z*z + c over one shared 32x32 multiplier.
// Depends on mbrot_pkg.
`default_nettype none
module mbrot_back #(
  parameter int unsigned MAX_ITER  = 255,
  parameter int unsigned FRAC_BITS = 28
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                q_empty_i,
  input  mbrot_pkg::point_t                  q_data_i,
  output logic                               q_pop_o,
  output logic                               done_o,
  output logic [mbrot_pkg::GrayW-1:0]        gray_level_o,
  output logic                               in_set_o
);

  localparam int unsigned CntW   = $clog2(MAX_ITER + 1);
  localparam int unsigned TShift = 2 * FRAC_BITS + 2;
  localparam logic [63:0] Thresh = (TShift < 64) ? (64'd1 << TShift) : '1;

  mbrot_pkg::back_state_e state_q, state_d;
  logic signed [31:0] zr_q, zi_q, cr_q, ci_q, mul_a, mul_b;
  logic signed [63:0] rr_q, ii_q, ri_q, prod, nr, ni;
  logic [CntW-1:0]    cnt_q;
  logic [63:0]        mag;
  logic escaped, at_limit, finish;

  assign prod     = mul_a * mul_b;
  assign mag      = 64'(rr_q) + 64'(ii_q);
  assign escaped  = (cnt_q != '0) && (mag > Thresh);
  assign at_limit = (cnt_q == CntW'(MAX_ITER - 1));
  assign finish   = (state_q == mbrot_pkg::BeRi) && (escaped || at_limit);
  assign nr = ((rr_q - ii_q) >>> FRAC_BITS) + 64'(cr_q);
  assign ni = (ri_q >>> (FRAC_BITS - 1)) + 64'(ci_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbrot_pkg::BeIdle: if (!q_empty_i) state_d = mbrot_pkg::BeRr;
      mbrot_pkg::BeRr:   state_d = mbrot_pkg::BeIi;
      mbrot_pkg::BeIi:   state_d = mbrot_pkg::BeRi;
      mbrot_pkg::BeRi:   state_d = finish ? mbrot_pkg::BeIdle : mbrot_pkg::BeUpd;
      mbrot_pkg::BeUpd:  state_d = mbrot_pkg::BeRr;
      default:           state_d = mbrot_pkg::BeIdle;
    endcase
  end

  always_comb begin
    q_pop_o = (state_q == mbrot_pkg::BeIdle) && !q_empty_i;
    mul_a   = zr_q;
    mul_b   = zr_q;
    unique case (state_q)
      mbrot_pkg::BeIi: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      mbrot_pkg::BeRi: mul_b = zi_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbrot_pkg::BeIdle;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= finish;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      mbrot_pkg::BeIdle: begin
        cr_q  <= q_data_i.re;
        ci_q  <= q_data_i.im;
        zr_q  <= '0;
        zi_q  <= '0;
        cnt_q <= '0;
      end
      mbrot_pkg::BeRr: rr_q <= prod;
      mbrot_pkg::BeIi: ii_q <= prod;
      mbrot_pkg::BeRi: begin
        ri_q <= prod;
        if (escaped) begin
          in_set_o     <= 1'b0;
          gray_level_o <= (32'(cnt_q) >= 32'd254) ? 8'd1 : 8'(32'd255 - 32'(cnt_q));
        end else begin
          in_set_o     <= 1'b1;
          gray_level_o <= '0;
        end
      end
      mbrot_pkg::BeUpd: begin
        zr_q  <= mbrot_pkg::sat32(nr);
        zi_q  <= mbrot_pkg::sat32(ni);
        cnt_q <= cnt_q + CntW'(1);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
